// ===== design/prlv_pkg.sv =====
// Shared types, constants and register codes for the particle radius pipeline.
package prlv_pkg;

	localparam int GROUP_W  = 32;
	localparam int TYPE_W   = 8;
	localparam int VOL_W    = 40;
	localparam int LI_W     = 32;
	localparam int COEF_W   = 32;
	localparam int RAD_W    = 32;
	localparam int ROOT_W   = 28;
	localparam int ROOT_SQ_W = 2 * ROOT_W;
	localparam int X_W      = 3 * ROOT_W;
	localparam int K_W      = 30;
	localparam int VOL_LO_W = 20;
	localparam int VOL_HI_W = VOL_W - VOL_LO_W;
	localparam int X_FRAC_SHIFT = 12;

	localparam int FRONT_STAGES = 4;
	localparam int ROOT_STAGES  = ROOT_W;
	localparam int NUM_STAGES   = FRONT_STAGES + ROOT_STAGES;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_GROUP_SELECT        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_TYPE         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CARBON_TYPE         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_MOLAR_VOLUME = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CARBON_MOLAR_VOLUME = 3'd4;

	localparam logic [GROUP_W-1:0] RST_GROUP_SELECT        = 32'd1;
	localparam logic [TYPE_W-1:0]  RST_ACTIVE_TYPE         = 8'd1;
	localparam logic [TYPE_W-1:0]  RST_CARBON_TYPE         = 8'd2;
	localparam logic [COEF_W-1:0]  RST_ACTIVE_MOLAR_VOLUME = 32'd101658185;
	localparam logic [COEF_W-1:0]  RST_CARBON_MOLAR_VOLUME = 32'd82723419;

	// round(2^32 * 3 / (4 * pi))
	localparam logic [K_W-1:0] RADIUS_K = 30'd1025347913;

	localparam logic [VOL_W-1:0] VOL_MAX = {VOL_W{1'b1}};

	typedef struct packed {
		logic [GROUP_W-1:0] group_mask;
		logic [TYPE_W-1:0]  particle_type;
		logic [VOL_W-1:0]   base_volume;
		logic [LI_W-1:0]    lithium_amount;
		logic               last_particle;
	} particle_t;

	typedef struct packed {
		logic               updated;
		logic [VOL_W-1:0]   new_volume;
		logic [RAD_W-1:0]   new_radius;
		logic               last_out;
	} result_t;

	typedef struct packed {
		logic [GROUP_W-1:0] group_select;
		logic [TYPE_W-1:0]  active_type;
		logic [TYPE_W-1:0]  carbon_type;
		logic [COEF_W-1:0]  active_molar_volume;
		logic [COEF_W-1:0]  carbon_molar_volume;
	} cfg_t;

	// Cube root working set carried down the root stages
	typedef struct packed {
		logic                 upd;
		logic                 last;
		logic [VOL_W-1:0]     vol;
		logic [X_W-1:0]       rem;
		logic [ROOT_W-1:0]    y;
		logic [ROOT_SQ_W-1:0] y2;
	} root_t;

endpackage

// ===== design/prlv_cfg_regs.sv =====
// Configuration register file with plain write port.
module prlv_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [prlv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [prlv_pkg::CFG_DATA_W-1:0] cfg_data,
	output prlv_pkg::cfg_t                 cfg
);
	import prlv_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.group_select        <= RST_GROUP_SELECT;
			cfg_q.active_type         <= RST_ACTIVE_TYPE;
			cfg_q.carbon_type         <= RST_CARBON_TYPE;
			cfg_q.active_molar_volume <= RST_ACTIVE_MOLAR_VOLUME;
			cfg_q.carbon_molar_volume <= RST_CARBON_MOLAR_VOLUME;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GROUP_SELECT:        cfg_q.group_select        <= cfg_data;
				REG_ACTIVE_TYPE:         cfg_q.active_type         <= cfg_data[TYPE_W-1:0];
				REG_CARBON_TYPE:         cfg_q.carbon_type         <= cfg_data[TYPE_W-1:0];
				REG_ACTIVE_MOLAR_VOLUME: cfg_q.active_molar_volume <= cfg_data;
				REG_CARBON_MOLAR_VOLUME: cfg_q.carbon_molar_volume <= cfg_data;
				default: ; // drop writes to unused indexes
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/prlv_front.sv =====
// Front stages: qualify, coefficient product, saturating add, volume scaling.
module prlv_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  prlv_pkg::cfg_t                      cfg,
	input  logic                                in_v,
	input  prlv_pkg::particle_t                 particle,
	input  logic [prlv_pkg::FRONT_STAGES:1]     en,
	output logic [prlv_pkg::FRONT_STAGES:1]     vld,
	output prlv_pkg::root_t                     root
);
	import prlv_pkg::*;

	logic                      vld_s1, vld_s2, vld_s3, vld_s4;
	logic                      upd_s1, upd_s2, upd_s3, upd_s4;
	logic                      last_s1, last_s2, last_s3, last_s4;
	logic [VOL_W-1:0]          v0_s1;
	logic [2*COEF_W-1:0]       prod_s1;
	logic [VOL_W-1:0]          vol_s2, vol_s3, vol_s4;
	logic [VOL_HI_W+K_W-1:0]   ph_s3;
	logic [VOL_LO_W+K_W-1:0]   pl_s3;
	logic [X_W-1:0]            x_s4;

	logic                      grp_hit, is_active, is_carbon;
	logic [COEF_W-1:0]         coef;
	logic [VOL_W:0]            vol_sum;
	logic [VOL_HI_W+K_W+VOL_LO_W-1:0] vk;

	assign grp_hit   = |(particle.group_mask & cfg.group_select);
	assign is_active = particle.particle_type == cfg.active_type;
	assign is_carbon = particle.particle_type == cfg.carbon_type;
	assign coef      = is_active ? cfg.active_molar_volume : cfg.carbon_molar_volume;

	assign vol_sum = {1'b0, v0_s1} + {1'b0, prod_s1[2*COEF_W-1:24]};

	assign vk = {ph_s3, {VOL_LO_W{1'b0}}} + {{VOL_HI_W{1'b0}}, pl_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en[1]) vld_s1 <= in_v;
			if (en[2]) vld_s2 <= vld_s1;
			if (en[3]) vld_s3 <= vld_s2;
			if (en[4]) vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1] && in_v) begin
			upd_s1  <= grp_hit && (is_active || is_carbon);
			last_s1 <= particle.last_particle;
			v0_s1   <= particle.base_volume;
			prod_s1 <= coef * particle.lithium_amount;
		end
		if (en[2] && vld_s1) begin
			upd_s2  <= upd_s1;
			last_s2 <= last_s1;
			vol_s2  <= vol_sum[VOL_W] ? VOL_MAX : vol_sum[VOL_W-1:0];
		end
		if (en[3] && vld_s2) begin
			upd_s3  <= upd_s2;
			last_s3 <= last_s2;
			vol_s3  <= vol_s2;
			ph_s3   <= vol_s2[VOL_W-1:VOL_LO_W] * RADIUS_K;
			pl_s3   <= vol_s2[VOL_LO_W-1:0] * RADIUS_K;
		end
		if (en[4] && vld_s3) begin
			upd_s4  <= upd_s3;
			last_s4 <= last_s3;
			vol_s4  <= vol_s3;
			x_s4    <= {{(X_W-X_FRAC_SHIFT-$bits(vk)){1'b0}}, vk, {X_FRAC_SHIFT{1'b0}}};
		end
	end

	assign vld = {vld_s4, vld_s3, vld_s2, vld_s1};

	always_comb begin
		root.upd  = upd_s4;
		root.last = last_s4;
		root.vol  = vol_s4;
		root.rem  = x_s4;
		root.y    = '0;
		root.y2   = '0;
	end

endmodule

// ===== design/prlv_cbrt_stage.sv =====
// One restoring cube root step: fixes one result bit from three radicand bits.
module prlv_cbrt_stage #(
	parameter int SHIFT = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_v,
	input  prlv_pkg::root_t in_d,
	output logic            out_v,
	output prlv_pkg::root_t out_d
);
	import prlv_pkg::*;

	localparam int B_W = ROOT_SQ_W + 3;

	logic                 vld_s1;
	root_t                dat_s1;

	logic [ROOT_W-1:0]    yn;
	logic [ROOT_SQ_W-1:0] yn2;
	logic [ROOT_SQ_W:0]   t;
	logic [B_W-1:0]       b;
	logic [X_W-1:0]       hi;
	logic                 take;
	root_t                nxt;

	always_comb begin
		yn   = {in_d.y[ROOT_W-2:0], 1'b0};
		yn2  = {in_d.y2[ROOT_SQ_W-3:0], 2'b00};
		t    = {1'b0, yn2} + {{(ROOT_SQ_W-ROOT_W+1){1'b0}}, yn};
		// 3*(y^2 + y) + 1 for the doubled y
		b    = {2'b00, t} + {1'b0, t, 1'b0} + {{(B_W-1){1'b0}}, 1'b1};
		hi   = in_d.rem >> SHIFT;
		take = hi >= {{(X_W-B_W){1'b0}}, b};
		nxt  = in_d;
		if (take) begin
			nxt.rem = in_d.rem - ({{(X_W-B_W){1'b0}}, b} << SHIFT);
			nxt.y   = yn + {{(ROOT_W-1){1'b0}}, 1'b1};
			nxt.y2  = yn2 + {{(ROOT_SQ_W-ROOT_W-1){1'b0}}, yn, 1'b0}
				+ {{(ROOT_SQ_W-1){1'b0}}, 1'b1};
		end else begin
			nxt.y   = yn;
			nxt.y2  = yn2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_v) begin
			dat_s1 <= nxt;
		end
	end

	assign out_v = vld_s1;
	assign out_d = dat_s1;

endmodule

// ===== design/particle_radius_from_lithium_volume_unit.sv =====
// Top level: particle swelling pipeline, new volume and sphere radius per particle.
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+------------------------
//  particle  | in        | particle_valid / _stall   | particle (particle_t)
//  result    | out       | result_valid / _stall     | result (result_t)
//  config    | in        | cfg_we (no wait)          | cfg_index, cfg_data
//
//  The pipeline has 4 front stages (qualify and coefficient product,
//  saturating add, split volume-by-constant product, radicand assembly) and
//  28 cube root stages, one result bit each. One transaction enters per cycle
//  unless particle_stall is high. Reset clears all stage valid bits and loads the
//  register defaults. A stalled result holds in the last stage; earlier stages
//  keep advancing into empty slots, so bubbles close up before the input is stalled.
module particle_radius_from_lithium_volume_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [prlv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [prlv_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            particle_valid,
	output logic                            particle_stall,
	input  prlv_pkg::particle_t             particle,
	output logic                            result_valid,
	input  logic                            result_stall,
	output prlv_pkg::result_t               result
);
	import prlv_pkg::*;

	cfg_t  cfg;

	// valid and advance per stage; stage numbering starts at 1
	logic [NUM_STAGES:1]   vld;
	logic [NUM_STAGES+1:1] adv;

	root_t root_d [0:ROOT_STAGES];

	prlv_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// A stage advances when it is empty or its successor advances.
	// The slot past the last stage is the consumer taking the result.
	assign adv[NUM_STAGES+1] = ~result_stall;

	genvar gi;
	generate
		for (gi = 1; gi <= NUM_STAGES; gi++) begin : g_adv
			assign adv[gi] = ~vld[gi] | adv[gi+1];
		end
	endgenerate

	assign particle_stall = ~adv[1];

	prlv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_v     (particle_valid),
		.particle (particle),
		.en       (adv[FRONT_STAGES:1]),
		.vld      (vld[FRONT_STAGES:1]),
		.root     (root_d[0])
	);

	// Cube root chain; the first stage takes the top three radicand bits
	generate
		for (gi = 0; gi < ROOT_STAGES; gi++) begin : g_root
			prlv_cbrt_stage #(
				.SHIFT (3 * (ROOT_STAGES - 1 - gi))
			) u_stage (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (adv[FRONT_STAGES+1+gi]),
				.in_v   (vld[FRONT_STAGES+gi]),
				.in_d   (root_d[gi]),
				.out_v  (vld[FRONT_STAGES+1+gi]),
				.out_d  (root_d[gi+1])
			);
		end
	endgenerate

	// Skipped particles report zero volume and radius
	assign result_valid = vld[NUM_STAGES];
	always_comb begin
		result.updated    = root_d[ROOT_STAGES].upd;
		result.new_volume = root_d[ROOT_STAGES].upd ? root_d[ROOT_STAGES].vol : '0;
		result.new_radius = root_d[ROOT_STAGES].upd
			? {{(RAD_W-ROOT_W){1'b0}}, root_d[ROOT_STAGES].y} : '0;
		result.last_out   = root_d[ROOT_STAGES].last;
	end

`ifndef ASSERT_OFF
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		particle_valid && !particle_stall |=> vld[1])
		else $error("accepted transaction did not enter stage 1");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(root_d[ROOT_STAGES].y))
		else $error("stalled result lost or changed");

	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld[FRONT_STAGES] && !adv[FRONT_STAGES+1] |=> vld[FRONT_STAGES])
		else $error("front stage dropped a blocked transaction");
`endif

endmodule
